>>> rtl/core/partition_fit_allocator_unit_defines.svh
// Assertion macros shared by the partition fit allocator RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef PARTITION_FIT_ALLOCATOR_UNIT_DEFINES_SVH
`define PARTITION_FIT_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define PFA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pfa check failed");

// next-cycle implication
`define PFA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pfa check failed");

`endif

>>> rtl/core/pfa_pkg.sv
// Package for the partition fit allocator: constants, codes and shared types.
// No dependencies; imported by every module of the block.
package pfa_pkg;

	localparam int PFA_MAX_PARTS = 16;
	localparam int PFA_SIZE_BITS = 16;
	localparam int PFA_QDEPTH    = 2;
	localparam int PFA_IDX_W     = 4;
	localparam int PFA_DATA_W    = 16;
	localparam int PFA_CFG_W     = 5;

	localparam logic [1:0] PFA_POL_FIRST = 2'd0;
	localparam logic [1:0] PFA_POL_BEST  = 2'd1;
	localparam logic [1:0] PFA_POL_WORST = 2'd2;

	localparam logic PFA_REG_POLICY = 1'b0;
	localparam logic PFA_REG_PARTS  = 1'b1;

	localparam logic PFA_FUNC_LOAD = 1'b0;
	localparam logic PFA_FUNC_REQ  = 1'b1;

	typedef enum logic [1:0] {
		PFA_IDLE,
		PFA_SCAN,
		PFA_UPDATE
	} pfa_state_t;

	typedef struct packed {
		logic                  is_req;
		logic [PFA_IDX_W-1:0]  idx;
		logic [PFA_DATA_W-1:0] size;
	} pfa_cmd_t;

	typedef struct packed {
		logic [1:0]           policy;
		logic [PFA_CFG_W-1:0] parts;
	} pfa_cfg_t;

endpackage

>>> rtl/core/pfa_front.sv
// Front end: accepts input requests, decodes them into commands, drops
// loads aimed beyond the table. Depends on pfa_pkg.
module pfa_front #(
	parameter int MAX_PARTS = pfa_pkg::PFA_MAX_PARTS
) (
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic              func,
	input  logic [3:0]        part_index,
	input  logic [15:0]       size,
	output logic              push,
	output pfa_pkg::pfa_cmd_t cmd,
	input  logic              q_ready
);
	import pfa_pkg::*;

	logic keep;

	always_comb begin
		keep     = (func == PFA_FUNC_REQ) || ({28'd0, part_index} < 32'(MAX_PARTS));
		s_tready = q_ready;
		push     = s_tvalid && q_ready && keep;
		cmd.is_req = (func == PFA_FUNC_REQ);
		cmd.idx    = part_index;
		cmd.size   = size;
	end

endmodule

>>> rtl/core/pfa_fifo.sv
// Short command queue between front and back end.
// Depends on pfa_pkg for the command type.
module pfa_fifo #(
	parameter int DEPTH = pfa_pkg::PFA_QDEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  pfa_pkg::pfa_cmd_t push_data,
	output logic              push_ready,
	output logic              pop_valid,
	output pfa_pkg::pfa_cmd_t pop_data,
	input  logic              pop
);
	import pfa_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	pfa_cmd_t        slot_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	always_comb begin
		push_ready = (count_q != CW'(DEPTH));
		pop_valid  = (count_q != '0);
		pop_data   = slot_q[rd_ptr_q];
		do_push    = push && push_ready;
		do_pop     = pop && pop_valid;
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/core/pfa_back.sv
// Back end: free-space memory, sequential scan under the fit policy,
// update of the chosen partition and the result register. Depends on pfa_pkg.
`include "partition_fit_allocator_unit_defines.svh"
module pfa_back #(
	parameter int MAX_PARTS = pfa_pkg::PFA_MAX_PARTS,
	parameter int SIZE_BITS = pfa_pkg::PFA_SIZE_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  pfa_pkg::pfa_cfg_t cfg,
	input  logic              cmd_valid,
	input  pfa_pkg::pfa_cmd_t cmd,
	output logic              cmd_pop,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic              granted,
	output logic [3:0]        chosen_part,
	output logic [15:0]       space_left
);
	import pfa_pkg::*;

	localparam int AW = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
	localparam int CW = $clog2(MAX_PARTS + 1);

	pfa_state_t           state_q;
	pfa_state_t           state_d;

	logic [SIZE_BITS-1:0] mem [MAX_PARTS];
	logic [MAX_PARTS-1:0] valid_q;

	logic [CW-1:0]        limit;
	logic [CW-1:0]        addr_q;
	logic [SIZE_BITS-1:0] req_q;

	logic [SIZE_BITS-1:0] rd_data_s1;
	logic                 rd_ok_s1;
	logic                 rd_live_s1;
	logic [AW-1:0]        rd_idx_s1;

	logic                 found_q;
	logic [AW-1:0]        pick_q;
	logic [SIZE_BITS-1:0] pick_val_q;

	logic                 out_valid_q;
	logic                 out_granted_q;
	logic [3:0]           out_part_q;
	logic [15:0]          out_left_q;

	logic                 rd_en;
	logic                 scan_done;
	logic                 res_load;
	logic                 load_wr;
	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic [SIZE_BITS-1:0] wr_data;
	logic [SIZE_BITS-1:0] left;
	logic [SIZE_BITS-1:0] cand;
	logic                 take;

	always_comb begin
		if (32'(cfg.parts) > 32'(MAX_PARTS)) begin
			limit = CW'(MAX_PARTS);
		end else begin
			limit = CW'(cfg.parts);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			PFA_IDLE: begin
				if (cmd_valid && cmd.is_req) begin
					state_d = PFA_SCAN;
				end
			end
			PFA_SCAN: begin
				if (scan_done) begin
					state_d = PFA_UPDATE;
				end
			end
			PFA_UPDATE: begin
				if (res_load) begin
					state_d = PFA_IDLE;
				end
			end
			default: state_d = PFA_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		cmd_pop   = 1'b0;
		rd_en     = 1'b0;
		scan_done = 1'b0;
		res_load  = 1'b0;
		load_wr   = 1'b0;
		case (state_q)
			PFA_IDLE: begin
				cmd_pop = cmd_valid;
				load_wr = cmd_valid && !cmd.is_req;
			end
			PFA_SCAN: begin
				rd_en     = (addr_q < limit);
				scan_done = !rd_en && !rd_live_s1;
			end
			PFA_UPDATE: begin
				res_load = !out_valid_q || m_tready;
			end
			default: begin
				cmd_pop = 1'b0;
			end
		endcase
	end

	always_comb begin
		left = pick_val_q - req_q;
		cand = rd_ok_s1 ? rd_data_s1 : '0;
		take = 1'b0;
		if (rd_live_s1 && (cand >= req_q)) begin
			if (!found_q) begin
				take = 1'b1;
			end else begin
				case (cfg.policy)
					PFA_POL_FIRST: take = 1'b0;
					PFA_POL_BEST:  take = (cand < pick_val_q);
					default:       take = (cand > pick_val_q);
				endcase
			end
		end
		wr_en   = load_wr || (res_load && found_q);
		wr_addr = load_wr ? AW'(cmd.idx) : pick_q;
		wr_data = load_wr ? SIZE_BITS'(cmd.size) : left;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[addr_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_ok_s1  <= valid_q[addr_q[AW-1:0]];
			rd_idx_s1 <= addr_q[AW-1:0];
		end
		if (state_q == PFA_IDLE) begin
			req_q <= SIZE_BITS'(cmd.size);
		end
		if (take) begin
			pick_q     <= rd_idx_s1;
			pick_val_q <= cand;
		end
		if (res_load) begin
			out_granted_q <= found_q;
			out_part_q    <= found_q ? 4'(pick_q) : 4'd0;
			out_left_q    <= found_q ? 16'(left) : 16'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= PFA_IDLE;
			valid_q     <= '0;
			addr_q      <= '0;
			rd_live_s1  <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			rd_live_s1 <= rd_en;
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (state_q == PFA_IDLE) begin
				addr_q  <= '0;
				found_q <= 1'b0;
			end else begin
				if (rd_en) begin
					addr_q <= addr_q + 1'b1;
				end
				if (take) begin
					found_q <= 1'b1;
				end
			end
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid    = out_valid_q;
	assign granted     = out_granted_q;
	assign chosen_part = out_part_q;
	assign space_left  = out_left_q;

	`PFA_ASSERT_NOW(a_idle_no_read, clk, arst_n, state_q == PFA_IDLE, !rd_live_s1)
	`PFA_ASSERT_NOW(a_scan_in_range, clk, arst_n, state_q == PFA_SCAN, addr_q <= limit)
	`PFA_ASSERT_NOW(a_pick_in_range, clk, arst_n, res_load && found_q, 32'(pick_q) < 32'(limit))
	`PFA_ASSERT_NOW(a_wr_phase, clk, arst_n, wr_en, state_q == PFA_IDLE || state_q == PFA_UPDATE)
	`PFA_ASSERT_NEXT(a_result_after_update, clk, arst_n, res_load, out_valid_q)

endmodule

>>> rtl/core/partition_fit_allocator_unit.sv
// Load: written when it sits at the queue head with the back end idle; no result. Request:
// once it leaves the queue, the back end scans limit = min(parts_in_use, MAX_PARTS)
// partitions through a registered read stage, one partition a cycle on the single read port
// of the free-space memory, then loads the result register when it is empty or being drained,
// so a held result blocks it. No new command is taken until that result register is loaded.
// Reset clears control state and all per-partition valid bits; config: policy 0, 16 in use.
module partition_fit_allocator_unit #(
	parameter int MAX_PARTS = pfa_pkg::PFA_MAX_PARTS,
	parameter int SIZE_BITS = pfa_pkg::PFA_SIZE_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [3:0] part_index, [19:4] size, [23:20] zero
	input  logic        s_tuser,   // [0] func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [3:0] chosen_part, [19:4] space_left, [23:20] zero
	output logic        m_tuser,   // [0] granted
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [4:0]  cfg_data
);
	import pfa_pkg::*;

	pfa_cfg_t    cfg_q;
	pfa_cmd_t    fr_cmd;
	pfa_cmd_t    q_cmd;
	logic        fr_push;
	logic        q_ready;
	logic        q_valid;
	logic        q_pop;
	logic [3:0]  chosen_part;
	logic [15:0] space_left;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.policy <= PFA_POL_FIRST;
			cfg_q.parts  <= 5'd16;
		end else if (cfg_valid) begin
			case (cfg_index)
				PFA_REG_POLICY: cfg_q.policy <= cfg_data[1:0];
				PFA_REG_PARTS:  cfg_q.parts  <= cfg_data;
				default:        cfg_q        <= cfg_q;
			endcase
		end
	end

	pfa_front #(
		.MAX_PARTS (MAX_PARTS)
	) u_front (
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.func       (s_tuser),
		.part_index (s_tdata[3:0]),
		.size       (s_tdata[19:4]),
		.push       (fr_push),
		.cmd        (fr_cmd),
		.q_ready    (q_ready)
	);

	pfa_fifo #(
		.DEPTH (PFA_QDEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (fr_push),
		.push_data  (fr_cmd),
		.push_ready (q_ready),
		.pop_valid  (q_valid),
		.pop_data   (q_cmd),
		.pop        (q_pop)
	);

	pfa_back #(
		.MAX_PARTS (MAX_PARTS),
		.SIZE_BITS (SIZE_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.cmd_valid   (q_valid),
		.cmd         (q_cmd),
		.cmd_pop     (q_pop),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.granted     (m_tuser),
		.chosen_part (chosen_part),
		.space_left  (space_left)
	);

	assign m_tdata = {4'd0, space_left, chosen_part};

endmodule
